>>> sv/uxe_pkg.sv
// Shared types, constants and lookup functions for the XML escape encoder.
package uxe_pkg;

  localparam int unsigned CP_W   = 21;  // code point width
  localparam int unsigned QDEPTH = 2;   // job queue depth
  localparam int unsigned QPTR_W = 1;   // job queue pointer width
  localparam int unsigned QCNT_W = 2;   // job queue count width

  // Lead-byte thresholds and payload masks of UTF-8, and the printable ASCII range.
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD2_MIN = 8'hc0;
  localparam logic [7:0] PRINT_MAX = 8'h7e;
  localparam logic [7:0] PRINT_MIN = 8'h20;
  localparam logic [7:0] MASK_CONT = 8'h3f;
  localparam logic [7:0] MASK_L2   = 8'h1f;
  localparam logic [7:0] MASK_L3   = 8'h0f;
  localparam logic [7:0] MASK_L4   = 8'h07;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3c;
  localparam logic [7:0] CH_GT   = 8'h3e;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h61;

  typedef enum logic [1:0] {
    JOB_CHAR = 2'd0,  // pass one byte through
    JOB_ENT  = 2'd1,  // named entity
    JOB_NUM  = 2'd2   // numeric reference &#h;
  } job_kind_t;

  typedef enum logic [2:0] {
    ENT_QUOT = 3'd0,
    ENT_APOS = 3'd1,
    ENT_AMP  = 3'd2,
    ENT_LT   = 3'd3,
    ENT_GT   = 3'd4
  } ent_id_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [CP_W-1:0]  val;   // byte, entity id or code point
  } job_t;

  // Queue write signal from the front part.
  typedef struct packed {
    logic push;
  } q_wr_t;

  function automatic logic [2:0] ent_len(input logic [2:0] id);
    logic [2:0] len;
    case (id)
      ENT_QUOT: len = 3'd6;
      ENT_APOS: len = 3'd6;
      ENT_AMP:  len = 3'd5;
      ENT_LT:   len = 3'd4;
      ENT_GT:   len = 3'd4;
      default:  len = 3'd4;
    endcase
    return len;
  endfunction

  // Byte at position pos of the entity string.
  function automatic logic [7:0] ent_byte(input logic [2:0] id, input logic [2:0] pos);
    logic [47:0] s;
    logic [2:0]  idx;
    case (id)
      ENT_QUOT: s = "&quot;";
      ENT_APOS: s = "&apos;";
      ENT_AMP:  s = "&amp;";
      ENT_LT:   s = "&lt;";
      ENT_GT:   s = "&gt;";
      default:  s = "&gt;";
    endcase
    idx = ent_len(id) - 3'd1 - pos;
    return s[8*idx +: 8];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> sv/uxe_if.sv
// Stream interfaces for the encoder's input bytes and output characters.
interface uxe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface uxe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

>>> sv/uxe_front.sv
// Front part: accepts input bytes, tracks UTF-8 sequences and queues emit jobs.
module uxe_front (
  input  logic          clk,
  input  logic          rst_n,
  uxe_in_if.sink        in_ch,
  input  logic          q_full,
  output uxe_pkg::q_wr_t q_wr,
  output uxe_pkg::job_t push_job
);
  import uxe_pkg::*;

  logic [1:0]      rem_r, rem_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [CP_W-1:0] acc_or;
  logic [7:0]      c;
  logic            fire;
  logic            push;
  logic [4:0]      sh;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign sh          = 5'd6 * {3'd0, rem_r - 2'd1};
  assign acc_or      = acc_r | (CP_W'(c & MASK_CONT) << sh);

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    push     = 1'b0;
    push_job = '{kind: JOB_CHAR, val: CP_W'(c)};
    if (rem_r != 2'd0) begin
      rem_nxt = rem_r - 2'd1;
      acc_nxt = acc_or;
      if (rem_r == 2'd1) begin
        push     = 1'b1;
        push_job = '{kind: JOB_NUM, val: acc_or};
        acc_nxt  = '0;
      end
    end else if (c >= LEAD4_MIN) begin
      acc_nxt = CP_W'(c & MASK_L4) << 18;
      rem_nxt = 2'd3;
    end else if (c >= LEAD3_MIN) begin
      acc_nxt = CP_W'(c & MASK_L3) << 12;
      rem_nxt = 2'd2;
    end else if (c >= LEAD2_MIN) begin
      acc_nxt = CP_W'(c & MASK_L2) << 6;
      rem_nxt = 2'd1;
    end else begin
      push = 1'b1;
      case (c)
        CH_QUOT: push_job = '{kind: JOB_ENT, val: CP_W'(ENT_QUOT)};
        CH_APOS: push_job = '{kind: JOB_ENT, val: CP_W'(ENT_APOS)};
        CH_AMP:  push_job = '{kind: JOB_ENT, val: CP_W'(ENT_AMP)};
        CH_LT:   push_job = '{kind: JOB_ENT, val: CP_W'(ENT_LT)};
        CH_GT:   push_job = '{kind: JOB_ENT, val: CP_W'(ENT_GT)};
        default: begin
          if ((c >= PRINT_MIN && c <= PRINT_MAX) || c == CH_TAB || c == CH_LF ||
              c == CH_CR) begin
            push_job = '{kind: JOB_CHAR, val: CP_W'(c)};
          end else begin
            push_job = '{kind: JOB_NUM, val: CP_W'(c)};
          end
        end
      endcase
    end
  end

  assign q_wr.push = fire && push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      acc_r <= '0;
    end else if (fire) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> sv/uxe_queue.sv
// Two-entry job queue between the front and back parts.
module uxe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  uxe_pkg::q_wr_t q_wr,
  input  uxe_pkg::job_t  push_job,
  output logic           full,
  output logic           q_valid,
  output uxe_pkg::job_t  q_job,
  input  logic           pop
);
  import uxe_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)    rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({q_wr.push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/uxe_back.sv
// Back part: expands one job at a time into output characters.
module uxe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  uxe_pkg::job_t q_job,
  output logic          pop,
  uxe_out_if.source     out_ch
);
  import uxe_pkg::*;

  logic        cur_valid_r;
  job_t        cur_r;
  logic [3:0]  pos_r;
  logic [2:0]  ndig;
  logic [2:0]  dig_idx;
  logic [23:0] val24;
  logic [7:0]  ch;
  logic        last;
  logic        fire;
  logic        load;

  assign val24 = {3'd0, cur_r.val};

  // Hex digits needed, leading zeros dropped, at least one.
  always_comb begin
    if (val24[23:20] != 4'd0)      ndig = 3'd6;
    else if (val24[19:16] != 4'd0) ndig = 3'd5;
    else if (val24[15:12] != 4'd0) ndig = 3'd4;
    else if (val24[11:8] != 4'd0)  ndig = 3'd3;
    else if (val24[7:4] != 4'd0)   ndig = 3'd2;
    else                           ndig = 3'd1;
  end

  assign dig_idx = ndig + 3'd1 - pos_r[2:0];

  always_comb begin
    ch   = cur_r.val[7:0];
    last = 1'b1;
    case (cur_r.kind)
      JOB_CHAR: begin
        ch   = cur_r.val[7:0];
        last = 1'b1;
      end
      JOB_ENT: begin
        ch   = ent_byte(cur_r.val[2:0], pos_r[2:0]);
        last = (pos_r[2:0] == ent_len(cur_r.val[2:0]) - 3'd1);
      end
      JOB_NUM: begin
        last = (pos_r == {1'b0, ndig} + 4'd2);
        if (pos_r == 4'd0)      ch = CH_AMP;
        else if (pos_r == 4'd1) ch = CH_HASH;
        else if (last)          ch = CH_SEMI;
        else                    ch = hex_char(val24[4*dig_idx +: 4]);
      end
      default: begin
        ch   = cur_r.val[7:0];
        last = 1'b1;
      end
    endcase
  end

  assign out_ch.valid    = cur_valid_r;
  assign out_ch.out_char = ch;
  assign out_ch.out_last = last;

  assign fire = cur_valid_r && out_ch.ready;
  assign load = !cur_valid_r || (fire && last);
  assign pop  = load && q_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (load) begin
      cur_valid_r <= q_valid;
      pos_r       <= '0;
    end else if (fire) begin
      pos_r <= pos_r + 4'd1;
    end
  end

endmodule

>>> sv/utf8_xml_escape_encoder.sv
// Top level of the XML character escaper with UTF-8 numeric references.
//
//   Channel   Direction   Payload              Meaning of one beat
//   in_ch     sink        in_byte[7:0]         one raw byte of text
//   out_ch    source      out_char, out_last   one escaped ASCII byte
//
// Plain text passes at one beat per cycle in and out while the output is not
// stalled, registered in the job queue and then in the back emitter's current
// job. An escape emits one output beat per character, up to nine characters
// for a six-digit numeric reference, and input continues until the two-entry
// job queue fills. Lead and middle bytes of a UTF-8 sequence give no beat.
// Reset is synchronous and active low and clears queue and sequence state.
// Either side may stall at any time without loss or duplication.
module utf8_xml_escape_encoder (
  input  logic      clk,
  input  logic      rst_n,
  uxe_in_if.sink    in_ch,
  uxe_out_if.source out_ch
);
  import uxe_pkg::*;

  // The front decodes sequence state and classifies each single byte or finished
  // sequence into a job: pass through, named entity, or numeric reference with its value.
  q_wr_t q_wr;
  job_t  push_job;
  logic  q_full;
  logic  q_valid;
  job_t  q_job;
  logic  pop;

  uxe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .push_job (push_job)
  );

  // The queue decouples the two sides so a long escape does not stop input
  // right away.
  uxe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_wr     (q_wr),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop)
  );

  // The back holds the current job and steps through its characters; it
  // loads the next job in the same cycle the last character is taken.
  uxe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> sv/uxe_checker.sv
// Port-level checker for the escape encoder and its bind to the top level.
module uxe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);
  import uxe_pkg::*;

  // Nothing is presented in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // An ampersand only ever opens an escape, so it never ends a group.
  a_amp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == CH_AMP |-> !out_last)
    else $error("ampersand marked as last beat");

  // Every output character is printable ASCII, tab, LF or CR.
  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char >= PRINT_MIN && out_char <= PRINT_MAX) ||
                   out_char == CH_TAB || out_char == CH_LF || out_char == CH_CR))
    else $error("non-printable output character");

  // A stalled beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output beat changed");

endmodule

bind utf8_xml_escape_encoder uxe_checker u_uxe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_last  (out_ch.out_last)
);
